FILE: rtl/tccw_pkg.sv
// Shared types and constants of the text console cell writer.
`default_nettype none

package tccw_pkg;

	typedef enum logic [1:0] {
		ACT_PRINT      = 2'd0,
		ACT_SET_CURSOR = 2'd1,
		ACT_CLEAR      = 2'd2,
		ACT_READ       = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_EMIT
	} state_t;

	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'h0F;

endpackage

`default_nettype wire

FILE: rtl/tccw_cmd_if.sv
// Command channel: one console action per beat.
`default_nettype none

interface tccw_cmd_if;
	logic                valid;
	logic                ready;
	tccw_pkg::action_t   action;
	logic [7:0]          char_code;
	logic [7:0]          column;
	logic [7:0]          row;

	modport source (output valid, action, char_code, column, row, input ready);
	modport sink   (input valid, action, char_code, column, row, output ready);
endinterface

`default_nettype wire

FILE: rtl/tccw_rsp_if.sv
// Response channel: cursor state and read data, one beat per command.
`default_nettype none

interface tccw_rsp_if;
	logic        valid;
	logic        ready;
	logic [6:0]  cursor_column;
	logic [4:0]  cursor_row;
	logic [10:0] cursor_position;
	logic        scrolled;
	logic [7:0]  read_char;
	logic [7:0]  read_color;

	modport source (output valid, cursor_column, cursor_row, cursor_position, scrolled,
		read_char, read_color, input ready);
	modport sink   (input valid, cursor_column, cursor_row, cursor_position, scrolled,
		read_char, read_color, output ready);
endinterface

`default_nettype wire

FILE: rtl/text_console_cell_writer_core.sv
// Text console engine: cell memory, cursor, scroll and clear sequencer.
//
//  channel | dir | handshake       | payload
//  cmd     | in  | valid / ready   | action, char_code, column, row
//  rsp     | out | valid / ready   | cursor_column, cursor_row, cursor_position,
//          |     |                 | scrolled, read_char, read_color
//  cfg     | in  | cfg_we          | cfg_wdata = text_color
//
// Print, set cursor and read: accept, then ST_EMIT, then the response register.
// A print that scrolls copies the rows up through the single memory port pair, then
// blanks the bottom row; clear first refills the whole cell memory with blanks.
// After reset the cell memory is filled with blanks, during which cmd.ready
// stays low. A held response stalls only the next completion.
`default_nettype none

module text_console_cell_writer_core #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [7:0]  cfg_wdata,
	tccw_cmd_if.sink   cmd,
	tccw_rsp_if.source rsp
);

	localparam int CELLS   = COLUMNS * ROWS;
	localparam int AW      = $clog2(CELLS);
	localparam int CLW     = $clog2(COLUMNS);
	localparam int RW      = (ROWS > 2) ? $clog2(ROWS) : 1;
	localparam int EW      = $clog2(COLUMNS + TAB_STOP + 1);
	localparam int PW      = (AW > 11) ? AW : 11;
	localparam int SHIFT_N = (ROWS - 1) * COLUMNS;
	localparam int RECIP   = (65536 + TAB_STOP - 1) / TAB_STOP;

	// cell memory: attribute in [15:8], character in [7:0]
	logic [15:0] mem [CELLS];
	logic [15:0] rdata_q;

	tccw_pkg::state_t state_q, state_d;
	logic [AW-1:0]  cnt_q, cnt_d;
	logic [CLW-1:0] col_q, col_d;
	logic [RW-1:0]  row_q, row_d;
	logic           scrolled_q, scrolled_d;
	logic           is_read_q, is_read_d;
	logic           clr_emit_q, clr_emit_d;
	logic [7:0]     fill_color_q, fill_color_d;
	logic [7:0]     text_color_q;

	logic           mem_we, mem_re;
	logic [AW-1:0]  mem_wa, mem_ra;
	logic [15:0]    mem_wd;
	logic           out_load;

	logic           out_valid_q;
	logic [6:0]     out_col_q;
	logic [4:0]     out_row_q;
	logic [10:0]    out_pos_q;
	logic           out_scrolled_q;
	logic [7:0]     out_char_q;
	logic [7:0]     out_color_q;

	// print decode
	logic [EW-1:0]      col_x, pr_col_e, tab_stop;
	logic [CLW+15:0]    tab_prod;
	logic [CLW-1:0]     tab_quo;
	logic [CLW-1:0]     pr_wcol, pr_col;
	logic [RW:0]        pr_row_e;
	logic [RW-1:0]      pr_row;
	logic               pr_inc, pr_we, pr_scroll;
	logic [7:0]         pr_char;
	logic [AW-1:0]      pr_addr;

	// set / read position
	logic [CLW-1:0]     cl_col;
	logic [RW-1:0]      cl_row;
	logic [AW-1:0]      cl_addr;
	logic [PW-1:0]      pos_w;

	always_comb begin
		col_x    = EW'(col_q);
		tab_prod = (CLW + 16)'(col_q) * (CLW + 16)'(RECIP);
		tab_quo  = tab_prod[16 +: CLW];
		tab_stop = (EW'(tab_quo) + EW'(1)) * EW'(TAB_STOP);
		pr_col_e = col_x;
		pr_inc   = 1'b0;
		pr_we    = 1'b0;
		pr_wcol  = col_q;
		pr_char  = cmd.char_code;
		unique case (cmd.char_code)
			tccw_pkg::CH_NEWLINE: begin
				pr_col_e = '0;
				pr_inc   = 1'b1;
			end
			tccw_pkg::CH_RETURN: begin
				pr_col_e = '0;
			end
			tccw_pkg::CH_TAB: begin
				pr_col_e = tab_stop;
			end
			tccw_pkg::CH_BACKSPACE: begin
				if (col_q != '0) begin
					pr_col_e = col_x - EW'(1);
					pr_we    = 1'b1;
					pr_wcol  = col_q - CLW'(1);
					pr_char  = tccw_pkg::CH_SPACE;
				end
			end
			default: begin
				pr_we    = 1'b1;
				pr_col_e = col_x + EW'(1);
			end
		endcase
		// wrap past the last column
		if (pr_col_e >= EW'(COLUMNS)) begin
			pr_col = '0;
			pr_inc = 1'b1;
		end else begin
			pr_col = pr_col_e[CLW-1:0];
		end
		pr_row_e = (RW + 1)'(row_q) + (RW + 1)'(pr_inc);
		if (pr_row_e >= (RW + 1)'(ROWS)) begin
			pr_row    = RW'(ROWS - 1);
			pr_scroll = 1'b1;
		end else begin
			pr_row    = pr_row_e[RW-1:0];
			pr_scroll = 1'b0;
		end
		pr_addr = AW'(row_q) * AW'(COLUMNS) + AW'(pr_wcol);

		cl_col  = (cmd.column >= 8'(COLUMNS)) ? CLW'(COLUMNS - 1) : cmd.column[CLW-1:0];
		cl_row  = (cmd.row >= 8'(ROWS)) ? RW'(ROWS - 1) : cmd.row[RW-1:0];
		cl_addr = AW'(cl_row) * AW'(COLUMNS) + AW'(cl_col);

		pos_w   = PW'(row_q) * PW'(COLUMNS) + PW'(col_q);
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		col_d        = col_q;
		row_d        = row_q;
		scrolled_d   = scrolled_q;
		is_read_d    = is_read_q;
		clr_emit_d   = clr_emit_q;
		fill_color_d = fill_color_q;
		mem_we       = 1'b0;
		mem_wa       = '0;
		mem_wd       = '0;
		mem_re       = 1'b0;
		mem_ra       = '0;
		out_load     = 1'b0;
		cmd.ready    = 1'b0;
		unique case (state_q)
			tccw_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = {fill_color_q, tccw_pkg::CH_SPACE};
				if (cnt_q == AW'(CELLS - 1)) begin
					cnt_d      = '0;
					clr_emit_d = 1'b0;
					state_d    = clr_emit_q ? tccw_pkg::ST_EMIT : tccw_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			tccw_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					scrolled_d = 1'b0;
					is_read_d  = 1'b0;
					unique case (cmd.action)
						tccw_pkg::ACT_PRINT: begin
							mem_we = pr_we;
							mem_wa = pr_addr;
							mem_wd = {text_color_q, pr_char};
							col_d  = pr_col;
							row_d  = pr_row;
							if (pr_scroll) begin
								scrolled_d = 1'b1;
								cnt_d      = '0;
								state_d    = tccw_pkg::ST_SCROLL;
							end else begin
								state_d = tccw_pkg::ST_EMIT;
							end
						end
						tccw_pkg::ACT_SET_CURSOR: begin
							col_d   = cl_col;
							row_d   = cl_row;
							state_d = tccw_pkg::ST_EMIT;
						end
						tccw_pkg::ACT_CLEAR: begin
							col_d        = '0;
							row_d        = '0;
							fill_color_d = text_color_q;
							clr_emit_d   = 1'b1;
							cnt_d        = '0;
							state_d      = tccw_pkg::ST_CLEAR;
						end
						tccw_pkg::ACT_READ: begin
							mem_re    = 1'b1;
							mem_ra    = cl_addr;
							is_read_d = 1'b1;
							state_d   = tccw_pkg::ST_EMIT;
						end
						default: begin
							state_d = tccw_pkg::ST_EMIT;
						end
					endcase
				end
			end
			tccw_pkg::ST_SCROLL: begin
				// read one row ahead, write back what the previous cycle read
				if (cnt_q < AW'(SHIFT_N)) begin
					mem_re = 1'b1;
					mem_ra = cnt_q + AW'(COLUMNS);
				end
				if (cnt_q != '0) begin
					mem_we = 1'b1;
					mem_wa = cnt_q - AW'(1);
					mem_wd = rdata_q;
				end
				if (cnt_q == AW'(SHIFT_N)) begin
					state_d = tccw_pkg::ST_BLANK;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			tccw_pkg::ST_BLANK: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = {text_color_q, tccw_pkg::CH_SPACE};
				if (cnt_q == AW'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = tccw_pkg::ST_EMIT;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			tccw_pkg::ST_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = tccw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tccw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tccw_pkg::ST_CLEAR;
			cnt_q        <= '0;
			col_q        <= '0;
			row_q        <= '0;
			scrolled_q   <= 1'b0;
			is_read_q    <= 1'b0;
			clr_emit_q   <= 1'b0;
			fill_color_q <= tccw_pkg::RESET_COLOR;
			text_color_q <= tccw_pkg::RESET_COLOR;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			col_q        <= col_d;
			row_q        <= row_d;
			scrolled_q   <= scrolled_d;
			is_read_q    <= is_read_d;
			clr_emit_q   <= clr_emit_d;
			fill_color_q <= fill_color_d;
			if (cfg_we) begin
				text_color_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_col_q      <= 7'(col_q);
			out_row_q      <= 5'(row_q);
			out_pos_q      <= pos_w[10:0];
			out_scrolled_q <= scrolled_q;
			out_char_q     <= is_read_q ? rdata_q[7:0] : 8'h00;
			out_color_q    <= is_read_q ? rdata_q[15:8] : 8'h00;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.cursor_column   = out_col_q;
	assign rsp.cursor_row      = out_row_q;
	assign rsp.cursor_position = out_pos_q;
	assign rsp.scrolled        = out_scrolled_q;
	assign rsp.read_char       = out_char_q;
	assign rsp.read_color      = out_color_q;

	a_cursor_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(CLW + 1)'(col_q) < (CLW + 1)'(COLUMNS) && (RW + 1)'(row_q) < (RW + 1)'(ROWS))
		else $error("cursor outside the grid");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> mem_wa <= AW'(CELLS - 1))
		else $error("cell write beyond the grid");

	a_scroll_copy_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccw_pkg::ST_SCROLL && mem_re && mem_we) |-> mem_ra != mem_wa)
		else $error("scroll copy reads the cell it writes");

	a_scroll_on_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_scrolled_q) |-> out_row_q == 5'(ROWS - 1))
		else $error("scrolled response off the last row");

endmodule

`default_nettype wire
